// File: rtl/core/cfd_pkg.sv
`default_nettype none
package cfd_pkg;
   localparam int MaxTaps = 64;
   localparam int SampleWidth = 16;
   localparam int CoefWidth = 16;
   localparam int OutWidth = 38;
   localparam int IdxWidth = $clog2(MaxTaps);
   localparam int CntWidth = $clog2(MaxTaps + 1);
   localparam int RegWidth = 7;
   localparam int DecimMax = 64;

   localparam logic OP_LOAD_TAP = 1'b0;
   localparam logic OP_PUSH = 1'b1;

   localparam logic [0:0] CSR_DECIMATION = 1'b0;
   localparam logic [0:0] CSR_TAP_COUNT = 1'b1;

   // job handed from front to back: compute one output from the newest sample
   typedef struct packed {
      logic [CntWidth-1:0] taps;
      logic [IdxWidth-1:0] head;
   } job_type;
endpackage
`default_nettype wire

// File: rtl/core/cfd_req_if.sv
`default_nettype none
interface cfd_req_if;
   import cfd_pkg::*;
   logic valid;
   logic ready;
   logic op;
   logic [IdxWidth-1:0] tap_index;
   logic signed [CoefWidth-1:0] tap_value;
   logic signed [SampleWidth-1:0] sample_i;
   logic signed [SampleWidth-1:0] sample_q;
   modport source (output valid, op, tap_index, tap_value, sample_i, sample_q, input ready);
   modport sink (input valid, op, tap_index, tap_value, sample_i, sample_q, output ready);
endinterface
`default_nettype wire

// File: rtl/core/cfd_rsp_if.sv
`default_nettype none
interface cfd_rsp_if;
   import cfd_pkg::*;
   logic valid;
   logic ready;
   logic signed [OutWidth-1:0] out_i;
   logic signed [OutWidth-1:0] out_q;
   modport source (output valid, out_i, out_q, input ready);
   modport sink (input valid, out_i, out_q, output ready);
endinterface
`default_nettype wire

// File: rtl/core/cfd_back.sv
`default_nettype none
// Serial MAC over the window; reads tap and sample memories one entry a cycle.
module cfd_back import cfd_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic job_valid,
   input wire job_type job,
   output logic job_ready,
   input wire logic tap_we,
   input wire logic [IdxWidth-1:0] tap_addr,
   input wire logic signed [CoefWidth-1:0] tap_data,
   input wire logic smp_we,
   input wire logic [IdxWidth-1:0] smp_addr,
   input wire logic signed [SampleWidth-1:0] smp_i,
   input wire logic signed [SampleWidth-1:0] smp_q,
   cfd_rsp_if.source rsp
);
   typedef enum logic [1:0] {IDLE, READ, MAC, DONE} state_type;

   logic signed [CoefWidth-1:0] coef_mem [MaxTaps];
   logic signed [SampleWidth-1:0] line_i_mem [MaxTaps];
   logic signed [SampleWidth-1:0] line_q_mem [MaxTaps];

   state_type state_ff;
   logic [CntWidth-1:0] cnt_ff, taps_ff;
   logic [IdxWidth-1:0] rd_ptr_ff;
   logic [IdxWidth-1:0] ti_ff;
   logic signed [CoefWidth-1:0] coef_rd_ff;
   logic signed [SampleWidth-1:0] si_rd_ff, sq_rd_ff;
   logic rd_live_ff;
   logic signed [SampleWidth+CoefWidth-1:0] prod_i_ff, prod_q_ff;
   logic prod_live_ff;
   logic signed [OutWidth-1:0] acc_i_ff, acc_q_ff;
   logic rsp_valid_ff;
   logic signed [OutWidth-1:0] out_i_ff, out_q_ff;

   always_ff @(posedge clock) begin
      if (tap_we) coef_mem[tap_addr] <= tap_data;
      if (smp_we) begin
         line_i_mem[smp_addr] <= smp_i;
         line_q_mem[smp_addr] <= smp_q;
      end
      coef_rd_ff <= coef_mem[ti_ff];
      si_rd_ff <= line_i_mem[rd_ptr_ff];
      sq_rd_ff <= line_q_mem[rd_ptr_ff];
   end

   assign job_ready = (state_ff == IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.out_i = out_i_ff;
   assign rsp.out_q = out_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         rsp_valid_ff <= 1'b0;
         rd_live_ff <= 1'b0;
         prod_live_ff <= 1'b0;
      end else begin
         if (state_ff == DONE && (!rsp_valid_ff || rsp.ready)) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         prod_i_ff <= si_rd_ff * coef_rd_ff;
         prod_q_ff <= sq_rd_ff * coef_rd_ff;
         prod_live_ff <= rd_live_ff;
         if (prod_live_ff) begin
            acc_i_ff <= acc_i_ff + OutWidth'(prod_i_ff);
            acc_q_ff <= acc_q_ff + OutWidth'(prod_q_ff);
         end
         unique case (state_ff)
            IDLE: begin
               rd_live_ff <= 1'b0;
               if (job_valid) begin
                  // oldest sample of the window pairs with tap 0
                  rd_ptr_ff <= job.head - IdxWidth'(job.taps - 1'b1);
                  ti_ff <= '0;
                  taps_ff <= job.taps;
                  cnt_ff <= '0;
                  acc_i_ff <= '0;
                  acc_q_ff <= '0;
                  state_ff <= READ;
               end
            end
            READ: begin
               rd_live_ff <= 1'b1;
               rd_ptr_ff <= rd_ptr_ff + 1'b1;
               ti_ff <= ti_ff + 1'b1;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff + 1'b1 == taps_ff) state_ff <= MAC;
            end
            MAC: begin
               rd_live_ff <= 1'b0;
               // drain the read and multiply stages
               if (!rd_live_ff && !prod_live_ff) state_ff <= DONE;
            end
            DONE: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  out_i_ff <= acc_i_ff;
                  out_q_ff <= acc_q_ff;
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_no_job_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != IDLE) |-> !job_ready) else $error("job ready while busy");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> (rsp_valid_ff && $stable(out_i_ff)))
      else $error("result changed while stalled");
   a_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == READ) |-> (cnt_ff < taps_ff)) else $error("count overrun");
`endif
endmodule
`default_nettype wire

// File: rtl/core/cfd_front.sv
`default_nettype none
// Accepts items, writes memories, tracks fill and phase, queues output jobs.
module cfd_front import cfd_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   cfd_req_if.sink req,
   input wire logic csr_write_enable,
   input wire logic [0:0] csr_index,
   input wire logic [RegWidth-1:0] csr_write_data,
   output logic job_valid,
   output job_type job,
   input wire logic job_ready,
   output logic tap_we,
   output logic [IdxWidth-1:0] tap_addr,
   output logic signed [CoefWidth-1:0] tap_data,
   output logic smp_we,
   output logic [IdxWidth-1:0] smp_addr,
   output logic signed [SampleWidth-1:0] smp_i,
   output logic signed [SampleWidth-1:0] smp_q
);
   logic [RegWidth-1:0] decim_ff, taps_reg_ff;
   logic [CntWidth-1:0] fill_ff;
   logic [IdxWidth-1:0] phase_ff;
   logic [IdxWidth-1:0] head_ff;
   logic busy_ff;
   job_type q_ff;
   logic qv_ff;

   logic [CntWidth-1:0] taps_use;
   logic [RegWidth-1:0] dec_use;
   logic fire, push, emit, pop;
   logic [IdxWidth-1:0] head_in;
   logic [CntWidth-1:0] fill_in;

   always_comb begin
      if (taps_reg_ff == '0) taps_use = CntWidth'(1);
      else if (taps_reg_ff > RegWidth'(MaxTaps)) taps_use = CntWidth'(MaxTaps);
      else taps_use = CntWidth'(taps_reg_ff);
      if (decim_ff == '0) dec_use = RegWidth'(1);
      else if (decim_ff > RegWidth'(DecimMax)) dec_use = RegWidth'(DecimMax);
      else dec_use = decim_ff;
   end

   // one item at a time: hold tap loads and samples while a job is queued or in flight
   assign req.ready = !busy_ff && !qv_ff;
   assign fire = req.valid && req.ready;
   assign push = fire && (req.op == OP_PUSH);
   assign head_in = head_ff + 1'b1;
   assign fill_in = fill_ff + 1'b1;
   always_comb begin
      emit = 1'b0;
      if (push) begin
         if (fill_ff < taps_use) emit = (fill_in == taps_use);
         else emit = ({1'b0, phase_ff} + 7'd1 >= dec_use);
      end
   end

   assign tap_we = fire && (req.op == OP_LOAD_TAP);
   assign tap_addr = req.tap_index;
   assign tap_data = req.tap_value;
   assign smp_we = push;
   assign smp_addr = head_in;
   assign smp_i = req.sample_i;
   assign smp_q = req.sample_q;

   assign job_valid = qv_ff;
   assign job = q_ff;
   assign pop = job_valid && job_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         decim_ff <= RegWidth'(1);
         taps_reg_ff <= RegWidth'(64);
         fill_ff <= '0;
         phase_ff <= '0;
         head_ff <= '0;
         qv_ff <= 1'b0;
         busy_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_DECIMATION: decim_ff <= csr_write_data;
               CSR_TAP_COUNT: taps_reg_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (push) begin
            head_ff <= head_in;
            if (fill_ff < CntWidth'(MaxTaps)) fill_ff <= fill_in;
            if (fill_ff < taps_use || emit) phase_ff <= '0;
            else phase_ff <= phase_ff + 1'b1;
         end
         // advance queue
         if (pop) begin
            qv_ff <= 1'b0;
            busy_ff <= 1'b1;
         end
         if (emit) begin
            q_ff.taps <= taps_use;
            q_ff.head <= head_in;
            qv_ff <= 1'b1;
         end
         if (busy_ff && job_ready && !pop) busy_ff <= 1'b0;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      emit |-> !qv_ff) else $error("job queue overflow");
   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CntWidth'(MaxTaps)) else $error("fill overrun");
   a_hold_busy: assert property (@(posedge clock) disable iff (reset)
      (busy_ff || qv_ff) |-> !req.ready) else $error("item taken while busy");
`endif
endmodule
`default_nettype wire

// File: rtl/core/complex_fir_decimator_unit.sv
`default_nettype none
// channel  | dir | payload
// req      | in  | op, tap_index, tap_value, sample_i, sample_q
// rsp      | out | out_i, out_q
// csr      | in  | csr_write_enable, csr_index, csr_write_data
// An item is taken while the MAC is idle. A sample that produces
// an output hands a job to the serial MAC, busy while it issues the job, reads
// each tap, drains the read and multiply stages and writes the result; the next
// item is taken only once the MAC is idle again and no job waits. Synchronous
// active-high reset clears control; memories need no clearing (sample reads stay
// inside filled entries). A stalled rsp holds its result while further items are
// taken; a second finished result waits in the MAC and holds off req.
module complex_fir_decimator_unit import cfd_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   cfd_req_if.sink req,
   cfd_rsp_if.source rsp,
   input wire logic csr_write_enable,
   input wire logic [0:0] csr_index,
   input wire logic [RegWidth-1:0] csr_write_data
);
   logic job_valid, job_ready, tap_we, smp_we;
   job_type job;
   logic [IdxWidth-1:0] tap_addr, smp_addr;
   logic signed [CoefWidth-1:0] tap_data;
   logic signed [SampleWidth-1:0] smp_i, smp_q;

   cfd_front u_front (.clock, .reset, .req, .csr_write_enable, .csr_index,
      .csr_write_data, .job_valid, .job, .job_ready, .tap_we, .tap_addr,
      .tap_data, .smp_we, .smp_addr, .smp_i, .smp_q);
   cfd_back u_back (.clock, .reset, .job_valid, .job, .job_ready, .tap_we,
      .tap_addr, .tap_data, .smp_we, .smp_addr, .smp_i, .smp_q, .rsp);
endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
   import cfd_pkg::*;

   typedef struct {
      logic                          op;
      logic [IdxWidth-1:0]           tap_index;
      logic signed [CoefWidth-1:0]   tap_value;
      logic signed [SampleWidth-1:0] sample_i;
      logic signed [SampleWidth-1:0] sample_q;
   } fir_item_type;

   typedef struct {
      logic signed [OutWidth-1:0] out_i;
      logic signed [OutWidth-1:0] out_q;
   } fir_sum_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [0:0] csr_index = CSR_DECIMATION;
   logic [RegWidth-1:0] csr_write_data = '0;

   cfd_req_if req ();
   cfd_rsp_if rsp ();

   complex_fir_decimator_unit dut (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // filter model state
   logic signed [SampleWidth-1:0] hist_i [MaxTaps];
   logic signed [SampleWidth-1:0] hist_q [MaxTaps];
   logic signed [CoefWidth-1:0]   coef [MaxTaps];
   int unsigned fill_cnt = 0;
   int unsigned phase_cnt = 0;
   logic [RegWidth-1:0] decim_reg = 7'd1;
   logic [RegWidth-1:0] taps_reg = 7'd64;

   fir_item_type pending_q [$];
   fir_sum_type  sums_q [$];
   int        errors = 0;
   int        sums_seen = 0;
   bit        idle_on = 1'b1;
   bit        hold_req = 1'b0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic fir_sum_type window_sum(int unsigned taps);
      fir_sum_type s;
      longint acc_i;
      longint acc_q;
      acc_i = 0;
      acc_q = 0;
      for (int k = 0; k < taps; k++) begin
         acc_i += longint'(hist_i[taps - 1 - k]) * longint'(coef[k]);
         acc_q += longint'(hist_q[taps - 1 - k]) * longint'(coef[k]);
      end
      s.out_i = acc_i[OutWidth-1:0];
      s.out_q = acc_q[OutWidth-1:0];
      return s;
   endfunction

   task automatic filter_accept(input fir_item_type it);
      int unsigned taps;
      int unsigned dec;
      taps = (taps_reg == 0) ? 1 : (taps_reg > MaxTaps) ? MaxTaps : taps_reg;
      dec = (decim_reg == 0) ? 1 : (decim_reg > DecimMax) ? DecimMax : decim_reg;
      if (it.op == OP_LOAD_TAP) begin
         coef[it.tap_index] = it.tap_value;
         return;
      end
      for (int k = MaxTaps - 1; k > 0; k--) begin
         hist_i[k] = hist_i[k - 1];
         hist_q[k] = hist_q[k - 1];
      end
      hist_i[0] = it.sample_i;
      hist_q[0] = it.sample_q;
      if (fill_cnt < taps) begin
         fill_cnt++;
         if (fill_cnt == taps) begin
            phase_cnt = 0;
            sums_q.push_back(window_sum(taps));
         end
         return;
      end
      if (fill_cnt < MaxTaps) fill_cnt++;
      if (phase_cnt + 1 >= dec) begin
         phase_cnt = 0;
         sums_q.push_back(window_sum(taps));
      end else begin
         phase_cnt++;
      end
   endtask

   // sender
   int send_gap = 0;
   always @(posedge clock) begin : sender
      fir_item_type it;
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) filter_accept(pending_q.pop_front());
         if (!req.valid || req.ready) begin
            if (send_gap > 0 || pending_q.size() == 0) begin
               if (send_gap > 0) send_gap--;
               req.valid <= 1'b0;
            end else begin
               it = pending_q[0];
               req.valid <= 1'b1;
               req.op <= it.op;
               req.tap_index <= it.tap_index;
               req.tap_value <= it.tap_value;
               req.sample_i <= it.sample_i;
               req.sample_q <= it.sample_q;
               send_gap = pick_gap();
            end
         end
      end
   end

   // receiver and checker
   int recv_gap = 0;
   int hold_left = 0;
   always @(posedge clock) begin : receiver
      fir_sum_type want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            sums_seen++;
            if (sums_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected output i=%0d q=%0d", rsp.out_i, rsp.out_q);
            end else begin
               want = sums_q.pop_front();
               if (want.out_i !== rsp.out_i || want.out_q !== rsp.out_q) begin
                  errors++;
                  if (errors <= 10)
                     $display("output %0d: expected i=%0d q=%0d, got i=%0d q=%0d",
                              sums_seen, want.out_i, want.out_q, rsp.out_i, rsp.out_q);
               end
            end
            recv_gap = pick_gap();
         end
         if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 600;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   function automatic logic signed [15:0] rand_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'sh8000;
      if (r == 1) return 16'sh7fff;
      return 16'($urandom);
   endfunction

   function automatic fir_item_type make_push(logic signed [15:0] vi, logic signed [15:0] vq);
      fir_item_type it;
      it.op = OP_PUSH;
      it.tap_index = 6'($urandom);
      it.tap_value = 16'($urandom);
      it.sample_i = vi;
      it.sample_q = vq;
      return it;
   endfunction

   function automatic fir_item_type make_load(logic [5:0] idx, logic signed [15:0] v);
      fir_item_type it;
      it = make_push(16'($urandom), 16'($urandom));
      it.op = OP_LOAD_TAP;
      it.tap_index = idx;
      it.tap_value = v;
      return it;
   endfunction

   task automatic wait_drained();
      while (pending_q.size() != 0 || req.valid || sums_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_regs(input logic [6:0] dec, input logic [6:0] taps);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_DECIMATION;
      csr_write_data <= dec;
      decim_reg = dec;
      @(posedge clock);
      csr_index <= CSR_TAP_COUNT;
      csr_write_data <= taps;
      taps_reg = taps;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_phase(input logic [6:0] dec, input logic [6:0] taps, input int n);
      wait_drained();
      write_regs(dec, taps);
      idle_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 9) == 0)
            pending_q.push_back(make_load(6'($urandom), rand_value()));
         else
            pending_q.push_back(make_push(rand_value(), rand_value()));
      end
   endtask

   initial begin
      logic [6:0] cfg_list [12][2];
      cfg_list = '{
         '{7'd1, 7'd4}, '{7'd64, 7'd3}, '{7'd0, 7'd0}, '{7'd127, 7'd127},
         '{7'd3, 7'd64}, '{7'd65, 7'd2}, '{7'd5, 7'd17}, '{7'd2, 7'd100},
         '{7'd1, 7'd1}, '{7'd8, 7'd33}, '{7'd4, 7'd9}, '{7'd1, 7'd64}
      };
      for (int k = 0; k < MaxTaps; k++) begin
         hist_i[k] = '0;
         hist_q[k] = '0;
         coef[k] = '0;
      end
      req.valid = 1'b0;
      req.op = OP_PUSH;
      req.tap_index = '0;
      req.tap_value = '0;
      req.sample_i = '0;
      req.sample_q = '0;
      rsp.ready = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // short window first, then widen it so filling resumes mid-stream
      write_regs(7'd1, 7'd2);
      for (int k = 0; k < MaxTaps; k++) pending_q.push_back(make_load(6'(k), 16'sh8000));
      for (int k = 0; k < 5; k++) pending_q.push_back(make_push(16'sh8000, 16'sh8000));
      wait_drained();
      write_regs(7'd1, 7'd64);
      idle_on = 1'b0;
      for (int k = 0; k < 62; k++) pending_q.push_back(make_push(16'sh8000, 16'sh7fff));
      pending_q.push_back(make_load(6'd63, 16'sh7fff));
      pending_q.push_back(make_push(16'sh7fff, 16'sh8000));
      pending_q.push_back(make_push(16'sh0000, 16'sh0000));

      // fresh taps, then random phases; hold the receiver off in the first one
      wait_drained();
      for (int k = 0; k < MaxTaps; k++) pending_q.push_back(make_load(6'(k), rand_value()));
      for (int p = 0; p < 12; p++) begin
         random_phase(cfg_list[p][0], cfg_list[p][1], 50);
         if (p == 0) hold_req = 1'b1;
      end
      for (int p = 0; p < 3; p++)
         random_phase(7'($urandom_range(1, 10)), 7'($urandom_range(1, 64)), 50);
      wait_drained();
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #(8 * 2_000_000);
      $display("tb: failure");
      $finish;
   end
endmodule

// File: files.f
rtl/core/cfd_pkg.sv
rtl/core/cfd_req_if.sv
rtl/core/cfd_rsp_if.sv
rtl/core/cfd_back.sv
rtl/core/cfd_front.sv
rtl/core/complex_fir_decimator_unit.sv
tb/sv/tb.sv
